// ===== hw/rtl/uabps_pkg.sv =====
package uabps_pkg;

   // Event kinds on the request channel
   localparam logic [1:0] EV_START = 2'd0;
   localparam logic [1:0] EV_TICK  = 2'd1;
   localparam logic [1:0] EV_FRAME = 2'd2;
   localparam logic [1:0] EV_ABORT = 2'd3;

   // Status codes
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_NODATA  = 3'd1;
   localparam logic [2:0] ST_NOMATCH = 3'd2;
   localparam logic [2:0] ST_PARITY  = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   // Register indexes on the CSR port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH = 1'd1;

   localparam logic [15:0] TIMEOUT_RST  = 16'd500;
   localparam logic [3:0]  MISMATCH_RST = 4'd3;

   localparam logic [2:0] LAST_RATE = 3'd6;

   // Judge flag masks
   localparam logic [5:0] FLG_MISMATCH = 6'h01;
   localparam logic [5:0] FLG_ANY_ERR  = 6'h3E;
   localparam logic [5:0] FLG_MODBUS   = 6'h06;
   localparam logic [5:0] FLG_SEVEN    = 6'h08;

   // Last framing position for each error class; SEVEN_FIRST is the first for seven-bit errors
   localparam logic [3:0] MODBUS_LAST = 4'd3;
   localparam logic [3:0] FRAME_LAST  = 4'd6;
   localparam logic [3:0] SEVEN_FIRST = 4'd4;

   typedef struct packed {
      logic       busy_res;
      logic [2:0] status;
      logic [2:0] baud_index;
      logic [2:0] baud_code;
      logic [2:0] parity_index;
      logic       reconfigure;
      logic       commit;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [3:0]  mismatch_limit;
   } cfg_type;

   // Search order of rates: 9600, 19200, 4800, 38400, 57600, 2400, 115200
   function automatic logic [2:0] rate_code(input logic [2:0] pos);
      logic [2:0] code;
      case (pos)
         3'd0:    code = 3'd2;
         3'd1:    code = 3'd3;
         3'd2:    code = 3'd1;
         3'd3:    code = 3'd4;
         3'd4:    code = 3'd5;
         3'd5:    code = 3'd0;
         3'd6:    code = 3'd6;
         default: code = 3'd2;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/uart_auto_baud_parity_search_top.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   kind, judge_flags
// rsp_      out        rsp_valid/rsp_ready   busy_res, status, baud_index, baud_code,
//                                            parity_index, reconfigure, commit
// csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// One request beat gives one response beat. The search state updates at the
// edge that accepts the request; the response lands in a two-entry buffer and
// is offered in order; one beat per cycle is sustained while rsp_ready is high.
// req_ready drops only while both buffer entries hold untaken responses.
// Reset is synchronous: it clears the search state, empties the buffer and
// loads timeout_ticks = 500 and mismatch_limit = 3. csr_ready is always high.
module uart_auto_baud_parity_search_top import uabps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [5:0]           req_judge_flags,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_busy_res,
   output logic [2:0]           rsp_status,
   output logic [2:0]           rsp_baud_index,
   output logic [2:0]           rsp_baud_code,
   output logic [2:0]           rsp_parity_index,
   output logic                 rsp_reconfigure,
   output logic                 rsp_commit,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   cfg_type cfg_ff, cfg_in;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    buf_full;
   logic    step;

   // Accept a beat whenever the buffer has room
   assign req_ready = !buf_full;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Hold register values; load the addressed one on a write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT:  cfg_in.timeout_ticks  = csr_data;
            CSR_MISMATCH: cfg_in.mismatch_limit = csr_data[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks  <= TIMEOUT_RST;
         cfg_ff.mismatch_limit <= MISMATCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uabps_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .kind        (req_kind),
      .judge_flags (req_judge_flags),
      .cfg         (cfg_ff),
      .result      (step_rsp)
   );

   uabps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (step_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_busy_res     = out_rsp.busy_res;
   assign rsp_status       = out_rsp.status;
   assign rsp_baud_index   = out_rsp.baud_index;
   assign rsp_baud_code    = out_rsp.baud_code;
   assign rsp_parity_index = out_rsp.parity_index;
   assign rsp_reconfigure  = out_rsp.reconfigure;
   assign rsp_commit       = out_rsp.commit;

endmodule

// ===== hw/rtl/uabps_core.sv =====
module uabps_core import uabps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] kind,
   input  logic [5:0] judge_flags,
   input  cfg_type    cfg,
   output rsp_type    result
);

   logic        active_ff, active_in;
   logic [2:0]  rate_pos_ff, rate_pos_in;
   logic [2:0]  frame_pos_ff, frame_pos_in;
   logic [3:0]  miss_count_ff, miss_count_in;
   logic        seen_data_ff, seen_data_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic [2:0]  result_code_ff, result_code_in;
   logic        reconf, commit;

   always_comb begin
      logic [15:0] tt;
      logic [3:0]  lim;
      logic [15:0] idle_inc;
      logic [3:0]  miss_inc;
      logic [3:0]  fnext;
      logic [3:0]  flimit;
      logic        rate_left;

      active_in      = active_ff;
      rate_pos_in    = rate_pos_ff;
      frame_pos_in   = frame_pos_ff;
      miss_count_in  = miss_count_ff;
      seen_data_in   = seen_data_ff;
      idle_ticks_in  = idle_ticks_ff;
      result_code_in = result_code_ff;
      reconf         = 1'b0;
      commit         = 1'b0;

      tt        = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
      lim       = (cfg.mismatch_limit == 4'd0) ? 4'd1 : cfg.mismatch_limit;
      idle_inc  = (idle_ticks_ff != 16'hFFFF) ? idle_ticks_ff + 16'd1 : idle_ticks_ff;
      miss_inc  = (miss_count_ff != 4'hF) ? miss_count_ff + 4'd1 : miss_count_ff;
      rate_left = (rate_pos_ff < LAST_RATE);

      // Pick the next framing and its limit for the error class
      if ((judge_flags & FLG_MODBUS) != 6'd0) begin
         fnext  = {1'b0, frame_pos_ff} + 4'd1;
         flimit = MODBUS_LAST;
      end else if ((judge_flags & FLG_SEVEN) != 6'd0) begin
         fnext  = ({1'b0, frame_pos_ff} < SEVEN_FIRST) ? SEVEN_FIRST
                                                       : {1'b0, frame_pos_ff} + 4'd1;
         flimit = FRAME_LAST;
      end else begin
         fnext  = {1'b0, frame_pos_ff} + 4'd1;
         flimit = FRAME_LAST;
      end

      case (kind)
         EV_START: begin
            active_in      = 1'b1;
            rate_pos_in    = 3'd0;
            frame_pos_in   = 3'd0;
            miss_count_in  = 4'd0;
            seen_data_in   = 1'b0;
            idle_ticks_in  = 16'd0;
            result_code_in = ST_NONE;
            reconf         = 1'b1;
         end
         EV_ABORT: begin
            // Clear a pending status first; only a clean abort stops the search
            if (result_code_ff != ST_NONE) begin
               result_code_in = ST_NONE;
            end else begin
               active_in = 1'b0;
            end
         end
         EV_TICK: begin
            if (active_ff) begin
               idle_ticks_in = idle_inc;
               if (idle_inc >= tt) begin
                  idle_ticks_in = 16'd0;
                  if (rate_left) begin
                     rate_pos_in = rate_pos_ff + 3'd1;
                     reconf      = 1'b1;
                  end else begin
                     active_in      = 1'b0;
                     result_code_in = seen_data_ff ? ST_NOMATCH : ST_NODATA;
                  end
               end
            end
         end
         default: begin
            if (active_ff) begin
               seen_data_in  = 1'b1;
               idle_ticks_in = 16'd0;
               if ((judge_flags & FLG_MISMATCH) != 6'd0) begin
                  miss_count_in = miss_inc;
                  if (miss_inc >= lim) begin
                     miss_count_in = 4'd0;
                     if (rate_left) begin
                        rate_pos_in  = rate_pos_ff + 3'd1;
                        frame_pos_in = 3'd0;
                        reconf       = 1'b1;
                     end else begin
                        active_in      = 1'b0;
                        result_code_in = ST_NOMATCH;
                     end
                  end
               end else if ((judge_flags & FLG_ANY_ERR) != 6'd0) begin
                  frame_pos_in = fnext[2:0];
                  if (fnext > flimit) begin
                     active_in      = 1'b0;
                     result_code_in = ST_PARITY;
                  end else begin
                     reconf = 1'b1;
                  end
               end else begin
                  commit         = 1'b1;
                  active_in      = 1'b0;
                  result_code_in = ST_FINISH;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         rate_pos_ff    <= 3'd0;
         frame_pos_ff   <= 3'd0;
         miss_count_ff  <= 4'd0;
         seen_data_ff   <= 1'b0;
         idle_ticks_ff  <= 16'd0;
         result_code_ff <= ST_NONE;
      end else if (step) begin
         active_ff      <= active_in;
         rate_pos_ff    <= rate_pos_in;
         frame_pos_ff   <= frame_pos_in;
         miss_count_ff  <= miss_count_in;
         seen_data_ff   <= seen_data_in;
         idle_ticks_ff  <= idle_ticks_in;
         result_code_ff <= result_code_in;
      end
   end

   always_comb begin
      result.busy_res     = active_in;
      result.status       = result_code_in;
      result.baud_index   = rate_pos_in;
      result.baud_code    = rate_code(rate_pos_in);
      result.parity_index = frame_pos_in;
      result.reconfigure  = reconf;
      result.commit       = commit;
   end

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      rate_pos_ff <= LAST_RATE)
      else $error("rate position passed the last rate");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      step |-> !(reconf && commit))
      else $error("reconfigure and commit in the same beat");

   a_commit_ends: assert property (@(posedge clock) disable iff (reset)
      step && commit |=> !active_ff && result_code_ff == ST_FINISH)
      else $error("commit did not end the search");

   a_busy_no_status: assert property (@(posedge clock) disable iff (reset)
      step && reconf |=> active_ff && result_code_ff == ST_NONE)
      else $error("reconfigure given while search not running");

endmodule

// ===== hw/rtl/uabps_rsp_buf.sv =====
module uabps_rsp_buf import uabps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full response buffer");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("pointers disagree with count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer count out of range");

endmodule
